### rtl/core/periodic_interval_timer_core_assert.svh
// Assertion macros for the periodic interval timer core.
`ifndef PERIODIC_INTERVAL_TIMER_CORE_ASSERT_SVH
`define PERIODIC_INTERVAL_TIMER_CORE_ASSERT_SVH

`ifndef SYNTH
`define PIT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PIT_ASSERT(label, prop, msg)
`define PIT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### rtl/core/pit_pkg.sv
// Types and constants shared by the periodic interval timer core.
`timescale 1ns / 1ps
`default_nettype none

package pit_pkg;

  // stream word widths; the tdata widths are padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam int unsigned OFFSET_W = 4;
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } pit_op_e;

  // register byte offsets
  localparam logic [OFFSET_W-1:0] OFF_MODE   = 4'd0;
  localparam logic [OFFSET_W-1:0] OFF_STATUS = 4'd4;
  localparam logic [OFFSET_W-1:0] OFF_VALUE  = 4'd8;
  localparam logic [OFFSET_W-1:0] OFF_IMAGE  = 4'd12;

  // mode register layout
  localparam logic [DATA_W-1:0] MODE_RESET   = 32'h000f_ffff;
  localparam int unsigned       MODE_EN_BIT  = 24;
  localparam int unsigned       MODE_IRQ_BIT = 25;

endpackage

`default_nettype wire

### rtl/core/periodic_interval_timer_core.sv
// Periodic interval timer core: bus registers and counters behind a stream port.
`timescale 1ns / 1ps
`default_nettype none

// Periodic interval timer with mode, status, value and image registers. Each
// input word is a prescaled tick, a bus read or a bus write (selected by
// tuser); each one yields exactly one output word carrying the read data (zero
// for anything but a mapped read) and the interrupt level after that word.
// The core takes one word per clock cycle and keeps that rate indefinitely as
// long as the output side is ready. A word passes an input register and a
// result register: it lands in the input register at the accepting edge, and
// its result moves into the result register once that one is free, where it is
// presented on the output. All counter and register updates happen in the
// single step between the two registers.
// While a result waits, the input register still takes the next word if it is
// empty; once it is full behind a stalled result, the input side is held off.
// Reading the value register returns elapsed count and period count and then
// clears status, period count and interrupt; reading the image register does
// not clear. Writing mode zeroes the elapsed counter.
module periodic_interval_timer_core #(
  parameter int unsigned COUNT_WIDTH   = 20,
  parameter int unsigned PERIODS_WIDTH = 12
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // [3:0] reg_offset, [35:4] write_data, [39:36] zero
  input  wire logic [pit_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // [1:0] opcode
  input  wire logic [pit_pkg::IN_TUSER_W-1:0]    s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // [31:0] read_data, [32] irq_line, [39:33] zero
  output logic [pit_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o
);

  import pit_pkg::*;

  // input register
  logic                in_valid_q;
  pit_op_e             in_op_q;
  logic [OFFSET_W-1:0] in_off_q;
  logic [DATA_W-1:0]   in_data_q;

  // result register
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  logic              out_irq_q;

  // timer state
  logic [DATA_W-1:0]        mode_q, mode_d;
  logic                     status_q, status_d;
  logic [PERIODS_WIDTH-1:0] period_q, period_d;
  logic [COUNT_WIDTH-1:0]   elapsed_q, elapsed_d;
  logic                     irq_q, irq_d;
  logic [DATA_W-1:0]        rdata_d;

  logic                   advance;
  logic                   in_fire;
  logic                   step;
  logic [COUNT_WIDTH-1:0] interval;
  logic [63:0]            value_wide;
  logic [DATA_W-1:0]      value_word;

  // The result register frees when empty or taken; the input register frees
  // when empty or when its word moves on.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign step            = in_valid_q && advance;

  assign interval   = mode_q[COUNT_WIDTH-1:0];
  // elapsed count low, period count above it, truncated to the bus width
  assign value_wide = (64'(period_q) << COUNT_WIDTH) | 64'(elapsed_q);
  assign value_word = value_wide[DATA_W-1:0];

  always_comb begin
    mode_d    = mode_q;
    status_d  = status_q;
    period_d  = period_q;
    elapsed_d = elapsed_q;
    irq_d     = irq_q;
    rdata_d   = '0;
    unique case (in_op_q)
      OP_TICK: begin
        // advance only while enabled; wrap when the interval is reached
        if (mode_q[MODE_EN_BIT]) begin
          if (elapsed_q == interval) begin
            elapsed_d = '0;
            status_d  = 1'b1;
            period_d  = period_q + 1'b1;
            if (mode_q[MODE_IRQ_BIT]) begin
              irq_d = 1'b1;
            end
          end else begin
            elapsed_d = elapsed_q + 1'b1;
          end
        end
      end
      OP_READ: begin
        unique case (in_off_q)
          OFF_MODE:   rdata_d = mode_q;
          OFF_STATUS: rdata_d = DATA_W'(status_q);
          OFF_VALUE: begin
            // return the old period count, then drop status, periods and irq
            rdata_d  = value_word;
            status_d = 1'b0;
            period_d = '0;
            irq_d    = 1'b0;
          end
          OFF_IMAGE:  rdata_d = value_word;
          default:    rdata_d = '0;
        endcase
      end
      OP_WRITE: begin
        if (in_off_q == OFF_MODE) begin
          mode_d    = in_data_q;
          elapsed_d = '0;
        end
      end
      default: ;
    endcase
  end

  // control and timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_RESET;
      status_q    <= 1'b0;
      period_q    <= '0;
      elapsed_q   <= '0;
      irq_q       <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (step) begin
        mode_q    <= mode_d;
        status_q  <= status_d;
        period_q  <= period_d;
        elapsed_q <= elapsed_d;
        irq_q     <= irq_d;
      end
    end
  end

  // payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_op_q   <= pit_op_e'(s_axis_tuser_i);
      in_off_q  <= s_axis_tdata_i[OFFSET_W-1:0];
      in_data_q <= s_axis_tdata_i[OFFSET_W +: DATA_W];
    end
    if (step) begin
      out_data_q <= rdata_d;
      out_irq_q  <= irq_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - DATA_W - 1)'(0), out_irq_q, out_data_q};

`include "periodic_interval_timer_core_assert.svh"

  // the counter never runs past the interval field
  `PIT_ASSERT(a_elapsed_in_range, elapsed_q <= interval, "elapsed count beyond interval")
  // the level in a fresh result is the level the timer now holds
  `PIT_ASSERT_NEXT(a_irq_matches, step, out_irq_q == irq_q, "result irq differs from state")
  // a value read clears status, period count and interrupt
  `PIT_ASSERT_NEXT(a_value_clears, step && in_op_q == OP_READ && in_off_q == OFF_VALUE, !status_q && !irq_q && period_q == '0, "value read did not clear")
  // a disabled timer ignores ticks
  `PIT_ASSERT_NEXT(a_disabled_hold, step && in_op_q == OP_TICK && !mode_q[MODE_EN_BIT], $stable(elapsed_q) && $stable(period_q), "tick moved a disabled timer")

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking stream testbench for the periodic interval timer core.
`timescale 1ns / 1ps

module testbench;
  import pit_pkg::*;

  // Counter widths of the instance under test
  localparam int unsigned COUNT_W   = 20;
  localparam int unsigned PERIODS_W = 12;

  // Opcode that the core ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Give up after this many cycles without a single handshake
  localparam int unsigned STALL_LIMIT = 2000;

  // Ticks in the run of back-to-back single-tick periods
  localparam int unsigned PERIOD_RUN_TICKS = 40;

  // Expected content of one output word
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_line;
  } timer_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  // Slave side, driven at the rising edge
  logic                   in_valid = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   in_ready;

  // Master side
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Shadow copy of the timer state
  logic [DATA_W-1:0]    mode_q;
  logic                 status_q;
  logic [PERIODS_W-1:0] period_cnt;
  logic [COUNT_W-1:0]   elapsed_cnt;
  logic                 irq_q;

  // Results still owed by the core, oldest first
  timer_result_t pending_results[$];

  int unsigned failures = 0;
  bit          idle_on  = 1'b1;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  periodic_interval_timer_core #(
    .COUNT_WIDTH  (COUNT_W),
    .PERIODS_WIDTH(PERIODS_W)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(in_ready),
    .s_axis_tdata_i (in_tdata),   // [3:0] reg_offset, [35:4] write_data, [39:36] zero
    .s_axis_tuser_i (in_tuser),   // [1:0] opcode
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (out_tdata)   // [31:0] read_data, [32] irq_line, [39:33] zero
  );

  // Bring the shadow state to its power-on values.
  task automatic clear_timer_model();
    mode_q      = MODE_RESET;
    status_q    = 1'b0;
    period_cnt  = '0;
    elapsed_cnt = '0;
    irq_q       = 1'b0;
  endtask

  // Apply one input word to the shadow state and return the word the core owes.
  function automatic timer_result_t advance_timer(logic [1:0] op, logic [OFFSET_W-1:0] off,
                                                  logic [DATA_W-1:0] data);
    timer_result_t res;
    logic [63:0]   value_word;
    res.read_data = '0;
    // Value and image carry the period count as it stood before the read
    value_word = 64'(elapsed_cnt) | (64'(period_cnt) << COUNT_W);
    case (op)
      OP_TICK: begin
        if (mode_q[MODE_EN_BIT]) begin
          if (elapsed_cnt == mode_q[COUNT_W-1:0]) begin
            // End of period: wrap, flag it, count it, maybe interrupt
            elapsed_cnt = '0;
            status_q    = 1'b1;
            period_cnt  = period_cnt + 1'b1;
            if (mode_q[MODE_IRQ_BIT]) irq_q = 1'b1;
          end else begin
            elapsed_cnt = elapsed_cnt + 1'b1;
          end
        end
      end
      OP_READ: begin
        case (off)
          OFF_MODE:   res.read_data = mode_q;
          OFF_STATUS: res.read_data = DATA_W'(status_q);
          OFF_VALUE: begin
            res.read_data = value_word[DATA_W-1:0];
            status_q      = 1'b0;
            period_cnt    = '0;
            irq_q         = 1'b0;
          end
          OFF_IMAGE:  res.read_data = value_word[DATA_W-1:0];
          default:    res.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        // Only the mode register takes writes; the interrupt line is kept
        if (off == OFF_MODE) begin
          mode_q      = data;
          elapsed_cnt = '0;
        end
      end
      default: ;
    endcase
    res.irq_line = irq_q;
    return res;
  endfunction

  // Offer one word, hold it until taken, then log what it should produce.
  task automatic send_word(logic [1:0] op, logic [OFFSET_W-1:0] off, logic [DATA_W-1:0] data);
    while (idle_on && ($urandom_range(99) < 37)) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W - DATA_W - OFFSET_W){1'b0}}, data, off};
    in_tuser <= op;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    pending_results.push_back(advance_timer(op, off, data));
  endtask

  // Hold the slave side quiet until the core owes nothing.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Mode word with the given interval and control bits, other bits random.
  function automatic logic [DATA_W-1:0] mode_word(logic [COUNT_W-1:0] interval, bit en, bit irq);
    logic [DATA_W-1:0] w;
    w                = $urandom;
    w[COUNT_W-1:0]   = interval;
    w[MODE_EN_BIT]   = en;
    w[MODE_IRQ_BIT]  = irq;
    return w;
  endfunction

  // Registers straight out of reset, an unmapped read and the unused opcode.
  task automatic test_reset_values();
    send_word(OP_READ, OFF_MODE, $urandom);
    send_word(OP_READ, OFF_STATUS, $urandom);
    send_word(OP_READ, OFF_IMAGE, $urandom);
    send_word(OP_READ, OFF_VALUE, $urandom);
    send_word(OP_TICK, OFF_MODE, $urandom);     // disabled: nothing moves
    send_word(OP_READ, 4'd3, $urandom);
    send_word(OP_UNUSED, OFF_VALUE, $urandom);
  endtask

  // One full period with interrupt, then the clearing and non-clearing reads.
  task automatic test_period_wrap();
    send_word(OP_WRITE, OFF_MODE, mode_word(20'd2, 1'b1, 1'b1));
    repeat (3) send_word(OP_TICK, OFFSET_W'($urandom_range(15)), $urandom);
    send_word(OP_READ, OFF_STATUS, 32'h0);
    send_word(OP_READ, OFF_IMAGE, 32'hffff_ffff);
    send_word(OP_READ, OFF_VALUE, 32'h0);
    send_word(OP_READ, OFF_STATUS, 32'hffff_ffff);
    // Interval zero without interrupt enable: every tick wraps, line stays low
    send_word(OP_WRITE, OFF_MODE, mode_word(20'd0, 1'b1, 1'b0));
    repeat (2) send_word(OP_TICK, OFF_MODE, $urandom);
    send_word(OP_READ, OFF_IMAGE, 32'h0);
  endtask

  // Writes to read-only and unmapped offsets, and the all-ones mode word.
  task automatic test_ignored_writes();
    send_word(OP_WRITE, OFF_STATUS, 32'hffff_ffff);
    send_word(OP_WRITE, 4'd15, 32'hffff_ffff);
    send_word(OP_WRITE, OFF_MODE, 32'hffff_ffff);
    send_word(OP_READ, OFF_MODE, 32'h0);
    send_word(OP_TICK, 4'd15, 32'h0);
    send_word(OP_READ, OFF_IMAGE, 32'h0);
    send_word(OP_READ, 4'd15, 32'hffff_ffff);
  endtask

  // Count a long run of one-tick periods without reading in between.
  task automatic test_period_run();
    send_word(OP_WRITE, OFF_MODE, mode_word(20'd0, 1'b1, 1'b1));
    repeat (PERIOD_RUN_TICKS) send_word(OP_TICK, OFFSET_W'($urandom_range(15)), $urandom);
    send_word(OP_READ, OFF_IMAGE, $urandom);
    send_word(OP_READ, OFF_VALUE, $urandom);
  endtask

  // Mostly short, enabled periods with reads in between; the rest is noise.
  task automatic test_random_traffic(int unsigned count);
    int unsigned       pick;
    logic [1:0]        op;
    logic [OFFSET_W-1:0] off;
    logic [DATA_W-1:0] data;
    repeat (count) begin
      pick = $urandom_range(99);
      off  = OFFSET_W'($urandom_range(15));
      data = $urandom;
      if (pick < 45) begin
        op = OP_TICK;
      end else if (pick < 70) begin
        op = OP_READ;
        case ($urandom_range(3))
          0: off = OFF_MODE;
          1: off = OFF_STATUS;
          2: off = OFF_VALUE;
          default: off = OFF_IMAGE;
        endcase
      end else if (pick < 75) begin
        op = OP_READ;
      end else if (pick < 85) begin
        op   = OP_WRITE;
        off  = OFF_MODE;
        data = mode_word(COUNT_W'($urandom_range(7)), $urandom_range(99) < 85,
                         1'($urandom_range(1)));
      end else if (pick < 90) begin
        op  = OP_WRITE;
        off = OFF_MODE;
      end else if (pick < 96) begin
        op = OP_WRITE;
      end else begin
        op = OP_UNUSED;
      end
      send_word(op, off, data);
    end
  endtask

  // Stall the master side at random whenever idling is allowed.
  always @(posedge clk_i) begin
    out_ready <= !(idle_on && ($urandom_range(99) < 37));
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    timer_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, out_tdata);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[DATA_W-1:0] !== want.read_data) begin
          $display("%0t: read_data mismatch, expected %h, got %h", $time, want.read_data,
                   out_tdata[DATA_W-1:0]);
          failures++;
        end
        if (out_tdata[DATA_W] !== want.irq_line) begin
          $display("%0t: irq_line mismatch, expected %b, got %b", $time, want.irq_line,
                   out_tdata[DATA_W]);
          failures++;
        end
      end
    end
  end

  // End the run if the core stops moving words in either direction.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    clear_timer_model();
    // Hold reset low for a while, then release it at an edge
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_period_wrap();
    test_ignored_writes();
    test_period_run();

    test_random_traffic(200);
    // Let every owed word come back before the next burst
    wait_until_drained();
    // Run a stretch with neither side idling
    idle_on = 1'b0;
    test_random_traffic(80);
    idle_on = 1'b1;
    test_random_traffic(200);

    // Drop valid, drain the outstanding words and allow the pipeline to settle
    wait_until_drained();
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) failures++;

    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
